// File: design/assert_macros.svh
// Assertion macros shared by the tracker RTL.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk, suspended while rst is high.
`define KT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define KT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/kt2ca_pkg.sv
// Shared types, constants, microcode and arithmetic helpers of the 2-D tracker.
// No dependencies; used by every module of the block.
package kt2ca_pkg;

   localparam int W = 32;                 // datapath word
   localparam int F = 16;                 // fraction bits
   localparam int CFG_W = 31;             // configuration register width
   localparam int VAR_W = 31;             // variance output width
   localparam int CFG_NUM = 6;
   localparam int CSR_IW = 3;

   localparam logic [CSR_IW-1:0] CSR_TIME_STEP = 3'd0;
   localparam logic [CSR_IW-1:0] CSR_PROC_NOISE_POS = 3'd1;
   localparam logic [CSR_IW-1:0] CSR_PROC_NOISE_VEL = 3'd2;
   localparam logic [CSR_IW-1:0] CSR_PROC_NOISE_ACC = 3'd3;
   localparam logic [CSR_IW-1:0] CSR_MEAS_NOISE_X = 3'd4;
   localparam logic [CSR_IW-1:0] CSR_MEAS_NOISE_Y = 3'd5;

   localparam longint ONE_Q = longint'(1) << F;
   localparam longint TENTH_Q = (ONE_Q + 5) / 10;
   localparam logic [CFG_W-1:0] RST_DT = CFG_W'(ONE_Q);
   localparam logic [CFG_W-1:0] RST_QPOS = CFG_W'(TENTH_Q);
   localparam logic [CFG_W-1:0] RST_QVEL = CFG_W'(TENTH_Q);
   localparam logic [CFG_W-1:0] RST_QACC = CFG_W'(100 * ONE_Q);
   localparam logic [CFG_W-1:0] RST_RX = CFG_W'(25 * ONE_Q);
   localparam logic [CFG_W-1:0] RST_RY = CFG_W'(25 * ONE_Q);

   // Scratch memory: two axis state blocks of nine words, then temporaries.
   localparam int UA_W = 6;
   localparam int MEM_DEPTH = 35;
   localparam int AXIS_SLOTS = 9;

   localparam logic [UA_W-1:0] A_X0 = 6'd0;
   localparam logic [UA_W-1:0] A_X1 = 6'd1;
   localparam logic [UA_W-1:0] A_X2 = 6'd2;
   localparam logic [UA_W-1:0] A_C0 = 6'd3;
   localparam logic [UA_W-1:0] A_C1 = 6'd4;
   localparam logic [UA_W-1:0] A_C2 = 6'd5;
   localparam logic [UA_W-1:0] A_C3 = 6'd6;
   localparam logic [UA_W-1:0] A_C4 = 6'd7;
   localparam logic [UA_W-1:0] A_C5 = 6'd8;
   localparam logic [UA_W-1:0] A_DT = 6'd18;
   localparam logic [UA_W-1:0] A_H = 6'd19;
   localparam logic [UA_W-1:0] A_TMP = 6'd20;
   localparam logic [UA_W-1:0] A_XP0 = 6'd21;
   localparam logic [UA_W-1:0] A_XP1 = 6'd22;
   localparam logic [UA_W-1:0] A_M00 = 6'd23;
   localparam logic [UA_W-1:0] A_M01 = 6'd24;
   localparam logic [UA_W-1:0] A_M02 = 6'd25;
   localparam logic [UA_W-1:0] A_M10 = 6'd26;
   localparam logic [UA_W-1:0] A_M11 = 6'd27;
   localparam logic [UA_W-1:0] A_M12 = 6'd28;
   localparam logic [UA_W-1:0] A_P20 = 6'd29;
   localparam logic [UA_W-1:0] A_S = 6'd30;
   localparam logic [UA_W-1:0] A_K0 = 6'd31;
   localparam logic [UA_W-1:0] A_K1 = 6'd32;
   localparam logic [UA_W-1:0] A_K2 = 6'd33;
   localparam logic [UA_W-1:0] A_IN = 6'd34;

   // Load sources, carried in the b field of a load.
   localparam logic [UA_W-1:0] SRC_DT = 6'd0;
   localparam logic [UA_W-1:0] SRC_Q0 = 6'd1;
   localparam logic [UA_W-1:0] SRC_Q1 = 6'd2;
   localparam logic [UA_W-1:0] SRC_Q2 = 6'd3;
   localparam logic [UA_W-1:0] SRC_R = 6'd4;
   localparam logic [UA_W-1:0] SRC_Z = 6'd5;

   localparam int PC_W = 7;
   localparam logic [PC_W-1:0] LAST_PC = 7'd73;

   typedef enum logic [2:0] {
      OP_LD,
      OP_MUL,
      OP_ADD,
      OP_SUB,
      OP_SHR,
      OP_DIV
   } op_type;

   typedef struct packed {
      op_type          op;
      logic [UA_W-1:0] dst;
      logic [UA_W-1:0] srca;
      logic [UA_W-1:0] srcb;
   } uop_type;

   typedef struct packed {
      logic    load_meas;
      logic    exec;
      logic    div_start;
      logic    wb;
      logic    load_out;
      logic    axis;
      uop_type uop;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
      logic div_done;
   } sts_type;

   function automatic uop_type mk(op_type op, logic [UA_W-1:0] d, logic [UA_W-1:0] a,
                                  logic [UA_W-1:0] b);
      uop_type u;
      u.op = op;
      u.dst = d;
      u.srca = a;
      u.srcb = b;
      return u;
   endfunction

   // One axis of predict and update; the controller runs it once per axis.
   function automatic uop_type uop_at(logic [PC_W-1:0] pc);
      uop_type u;
      unique case (pc)
         7'd0:  u = mk(OP_LD,  A_DT,  A_TMP, SRC_DT);
         7'd1:  u = mk(OP_MUL, A_TMP, A_DT,  A_DT);
         7'd2:  u = mk(OP_SHR, A_H,   A_TMP, A_TMP);
         7'd3:  u = mk(OP_MUL, A_TMP, A_DT,  A_X1);
         7'd4:  u = mk(OP_ADD, A_XP0, A_X0,  A_TMP);
         7'd5:  u = mk(OP_MUL, A_TMP, A_H,   A_X2);
         7'd6:  u = mk(OP_ADD, A_XP0, A_XP0, A_TMP);
         7'd7:  u = mk(OP_MUL, A_TMP, A_DT,  A_X2);
         7'd8:  u = mk(OP_ADD, A_XP1, A_X1,  A_TMP);
         7'd9:  u = mk(OP_MUL, A_TMP, A_DT,  A_C1);
         7'd10: u = mk(OP_ADD, A_M00, A_C0,  A_TMP);
         7'd11: u = mk(OP_MUL, A_TMP, A_H,   A_C2);
         7'd12: u = mk(OP_ADD, A_M00, A_M00, A_TMP);
         7'd13: u = mk(OP_MUL, A_TMP, A_DT,  A_C2);
         7'd14: u = mk(OP_ADD, A_M10, A_C1,  A_TMP);
         7'd15: u = mk(OP_MUL, A_TMP, A_DT,  A_C3);
         7'd16: u = mk(OP_ADD, A_M01, A_C1,  A_TMP);
         7'd17: u = mk(OP_MUL, A_TMP, A_H,   A_C4);
         7'd18: u = mk(OP_ADD, A_M01, A_M01, A_TMP);
         7'd19: u = mk(OP_MUL, A_TMP, A_DT,  A_C4);
         7'd20: u = mk(OP_ADD, A_M11, A_C3,  A_TMP);
         7'd21: u = mk(OP_MUL, A_TMP, A_DT,  A_C4);
         7'd22: u = mk(OP_ADD, A_M02, A_C2,  A_TMP);
         7'd23: u = mk(OP_MUL, A_TMP, A_H,   A_C5);
         7'd24: u = mk(OP_ADD, A_M02, A_M02, A_TMP);
         7'd25: u = mk(OP_MUL, A_TMP, A_DT,  A_C5);
         7'd26: u = mk(OP_ADD, A_M12, A_C4,  A_TMP);
         7'd27: u = mk(OP_MUL, A_TMP, A_M01, A_DT);
         7'd28: u = mk(OP_ADD, A_M00, A_M00, A_TMP);
         7'd29: u = mk(OP_MUL, A_TMP, A_M02, A_H);
         7'd30: u = mk(OP_ADD, A_M00, A_M00, A_TMP);
         7'd31: u = mk(OP_LD,  A_TMP, A_TMP, SRC_Q0);
         7'd32: u = mk(OP_ADD, A_M00, A_M00, A_TMP);
         7'd33: u = mk(OP_MUL, A_TMP, A_M02, A_DT);
         7'd34: u = mk(OP_ADD, A_M01, A_M01, A_TMP);
         7'd35: u = mk(OP_MUL, A_TMP, A_M11, A_DT);
         7'd36: u = mk(OP_ADD, A_M10, A_M10, A_TMP);
         7'd37: u = mk(OP_MUL, A_TMP, A_M12, A_H);
         7'd38: u = mk(OP_ADD, A_M10, A_M10, A_TMP);
         7'd39: u = mk(OP_MUL, A_TMP, A_M12, A_DT);
         7'd40: u = mk(OP_ADD, A_M11, A_M11, A_TMP);
         7'd41: u = mk(OP_LD,  A_TMP, A_TMP, SRC_Q1);
         7'd42: u = mk(OP_ADD, A_M11, A_M11, A_TMP);
         7'd43: u = mk(OP_MUL, A_TMP, A_C4,  A_DT);
         7'd44: u = mk(OP_ADD, A_P20, A_C2,  A_TMP);
         7'd45: u = mk(OP_MUL, A_TMP, A_C5,  A_H);
         7'd46: u = mk(OP_ADD, A_P20, A_P20, A_TMP);
         7'd47: u = mk(OP_LD,  A_TMP, A_TMP, SRC_Q2);
         7'd48: u = mk(OP_ADD, A_C5,  A_C5,  A_TMP);
         7'd49: u = mk(OP_LD,  A_TMP, A_TMP, SRC_R);
         7'd50: u = mk(OP_ADD, A_S,   A_M00, A_TMP);
         7'd51: u = mk(OP_DIV, A_K0,  A_M00, A_S);
         7'd52: u = mk(OP_DIV, A_K1,  A_M10, A_S);
         7'd53: u = mk(OP_DIV, A_K2,  A_P20, A_S);
         7'd54: u = mk(OP_LD,  A_TMP, A_TMP, SRC_Z);
         7'd55: u = mk(OP_SUB, A_IN,  A_TMP, A_XP0);
         7'd56: u = mk(OP_MUL, A_TMP, A_K0,  A_IN);
         7'd57: u = mk(OP_ADD, A_X0,  A_XP0, A_TMP);
         7'd58: u = mk(OP_MUL, A_TMP, A_K1,  A_IN);
         7'd59: u = mk(OP_ADD, A_X1,  A_XP1, A_TMP);
         7'd60: u = mk(OP_MUL, A_TMP, A_K2,  A_IN);
         7'd61: u = mk(OP_ADD, A_X2,  A_X2,  A_TMP);
         7'd62: u = mk(OP_MUL, A_TMP, A_K0,  A_M00);
         7'd63: u = mk(OP_SUB, A_C0,  A_M00, A_TMP);
         7'd64: u = mk(OP_MUL, A_TMP, A_K0,  A_M01);
         7'd65: u = mk(OP_SUB, A_C1,  A_M01, A_TMP);
         7'd66: u = mk(OP_MUL, A_TMP, A_K0,  A_M02);
         7'd67: u = mk(OP_SUB, A_C2,  A_M02, A_TMP);
         7'd68: u = mk(OP_MUL, A_TMP, A_K1,  A_M01);
         7'd69: u = mk(OP_SUB, A_C3,  A_M11, A_TMP);
         7'd70: u = mk(OP_MUL, A_TMP, A_K1,  A_M02);
         7'd71: u = mk(OP_SUB, A_C4,  A_M12, A_TMP);
         7'd72: u = mk(OP_MUL, A_TMP, A_K2,  A_M02);
         7'd73: u = mk(OP_SUB, A_C5,  A_C5,  A_TMP);
         default: u = mk(OP_LD, A_TMP, A_TMP, SRC_DT);
      endcase
      return u;
   endfunction

   // State words of the second axis sit right after those of the first.
   function automatic logic [UA_W-1:0] phys_addr(logic [UA_W-1:0] la, logic axis);
      if (axis && (la < UA_W'(AXIS_SLOTS))) begin
         return la + UA_W'(AXIS_SLOTS);
      end
      return la;
   endfunction

   function automatic logic [W-1:0] reset_val(logic [UA_W-1:0] pa);
      logic [W-1:0] v;
      v = '0;
      if ((pa == A_C0) || (pa == A_C0 + UA_W'(AXIS_SLOTS))) begin
         v = W'(100 * ONE_Q);
      end else if ((pa == A_C3) || (pa == A_C5) || (pa == A_C3 + UA_W'(AXIS_SLOTS)) ||
                   (pa == A_C5 + UA_W'(AXIS_SLOTS))) begin
         v = W'(TENTH_Q);
      end
      return v;
   endfunction

   function automatic logic signed [W-1:0] sat_add(logic signed [W-1:0] a,
                                                   logic signed [W-1:0] b, logic sub);
      logic signed [W:0] s;
      logic signed [W-1:0] r;
      s = sub ? ({a[W-1], a} - {b[W-1], b}) : ({a[W-1], a} + {b[W-1], b});
      if (s[W] != s[W-1]) begin
         r = s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
         r = s[W-1:0];
      end
      return r;
   endfunction

endpackage

// File: design/kalman_track_2d_const_accel.sv
// Top level of the two-axis constant-acceleration Kalman tracker.
// Depends on kt2ca_pkg, kt2ca_ctrl, kt2ca_dpath, kt2ca_div and assert_macros.svh.
//
//   Channel  Handshake             Word
//   req      req_valid/req_ready   req_meas_x, req_meas_y (signed Q16.16 fix)
//   rsp      rsp_valid/rsp_ready   rsp_est_* (signed), rsp_var_* (31-bit variances)
//   csr      csr_wr_en             csr_index, csr_wdata (six 31-bit registers)
//
// The sequencer issues one microcode operation at a time, each through its read,
// execute and write states: a load, add, subtract, shift or multiply passes straight
// through, and each of the three gain divisions per axis also waits, after execute,
// on the 48-step restoring divider; 74 operations run per axis.
// Reset is synchronous and active high and needs no clearing pass; the filter state
// reads as its reset value until first written. The next request word is taken while a
// finished result waits on rsp; a stalled rsp only holds back the end of the next word.
`include "assert_macros.svh"

module kalman_track_2d_const_accel (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic signed [31:0]          req_meas_x,
   input  logic signed [31:0]          req_meas_y,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [31:0]          rsp_est_pos_x,
   output logic signed [31:0]          rsp_est_vel_x,
   output logic signed [31:0]          rsp_est_acc_x,
   output logic signed [31:0]          rsp_est_pos_y,
   output logic signed [31:0]          rsp_est_vel_y,
   output logic signed [31:0]          rsp_est_acc_y,
   output logic [30:0]                 rsp_var_pos_x,
   output logic [30:0]                 rsp_var_vel_x,
   output logic [30:0]                 rsp_var_acc_x,
   output logic [30:0]                 rsp_var_pos_y,
   output logic [30:0]                 rsp_var_vel_y,
   output logic [30:0]                 rsp_var_acc_y,
   input  logic                        csr_wr_en,
   input  logic [kt2ca_pkg::CSR_IW-1:0] csr_index,
   input  logic [30:0]                 csr_wdata
);
   kt2ca_pkg::cmd_type cmd;
   kt2ca_pkg::sts_type sts;
   logic signed [kt2ca_pkg::W-1:0] est_out [6];
   logic [kt2ca_pkg::VAR_W-1:0] var_out [6];

   kt2ca_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   kt2ca_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .meas_x    (req_meas_x),
      .meas_y    (req_meas_y),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .est_out   (est_out),
      .var_out   (var_out)
   );

   // Result fields in port order: x axis then y axis.
   assign rsp_est_pos_x = est_out[0];
   assign rsp_est_vel_x = est_out[1];
   assign rsp_est_acc_x = est_out[2];
   assign rsp_est_pos_y = est_out[3];
   assign rsp_est_vel_y = est_out[4];
   assign rsp_est_acc_y = est_out[5];
   assign rsp_var_pos_x = var_out[0];
   assign rsp_var_vel_x = var_out[1];
   assign rsp_var_acc_x = var_out[2];
   assign rsp_var_pos_y = var_out[3];
   assign rsp_var_vel_y = var_out[4];
   assign rsp_var_acc_y = var_out[5];

   // An accepted word puts the sequencer to work at once.
   `KT_ASSERT(a_busy_after_accept, clock, reset, (req_valid && req_ready) |=> !req_ready, "ready stayed high after accept")
   // Loading the result register always raises the result valid.
   `KT_ASSERT(a_valid_after_load, clock, reset, cmd.load_out |=> rsp_valid, "result loaded without valid")
   // The divider is never restarted while a division is in flight.
   `KT_ASSERT(a_div_idle_start, clock, reset, cmd.div_start |-> !sts.div_busy, "divider started while busy")
   // No scratch write happens while the block waits for a request.
   `KT_ASSERT_ALWAYS(a_no_write_idle, clock, (!reset && req_ready) |-> !cmd.wb, "write while idle")
endmodule

// File: design/kt2ca_div.sv
// Restoring fixed-point divider, one quotient bit per cycle, truncating toward zero.
// Depends on kt2ca_pkg for widths.
module kt2ca_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic signed [kt2ca_pkg::W-1:0] num,
   input  logic signed [kt2ca_pkg::W-1:0] den,
   output logic                         busy,
   output logic                         done,
   output logic signed [kt2ca_pkg::W-1:0] quo
);
   localparam int W = kt2ca_pkg::W;
   localparam int NW = kt2ca_pkg::W + kt2ca_pkg::F;
   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0] n_ff, n_in, q_ff, q_in;
   logic [W-1:0] rem_ff, rem_in, ub_ff, ub_in;
   logic neg_ff, neg_in, busy_ff, busy_in, done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W:0] trial;
   logic ge;
   logic [W-1:0] mag_n, mag_d, lim, mag_q;

   always_comb begin
      mag_n = num[W-1] ? W'(-num) : W'(num);
      mag_d = den[W-1] ? W'(-den) : W'(den);
      trial = {rem_ff, n_ff[NW-1]};
      ge = trial >= {1'b0, ub_ff};
      n_in = n_ff;
      q_in = q_ff;
      rem_in = rem_ff;
      ub_in = ub_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         n_in = {mag_n, {kt2ca_pkg::F{1'b0}}};
         q_in = '0;
         rem_in = '0;
         ub_in = mag_d;
         neg_in = num[W-1] ^ den[W-1];
         cnt_in = CW'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         n_in = {n_ff[NW-2:0], 1'b0};
         q_in = {q_ff[NW-2:0], ge};
         rem_in = ge ? W'(trial - {1'b0, ub_ff}) : trial[W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      n_ff <= n_in;
      q_ff <= q_in;
      rem_ff <= rem_in;
      ub_ff <= ub_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
   end

   always_comb begin
      lim = neg_ff ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      mag_q = (q_ff > NW'(lim)) ? lim : q_ff[W-1:0];
      if (ub_ff == '0) begin
         quo = '0;
      end else begin
         quo = neg_ff ? -$signed(mag_q) : $signed(mag_q);
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
endmodule

// File: design/kt2ca_dpath.sv
// Datapath: configuration registers, scratch memory, saturating ALU, multiplier,
// divider and result capture. Depends on kt2ca_pkg and kt2ca_div.
module kt2ca_dpath (
   input  logic                            clock,
   input  logic                            reset,
   input  kt2ca_pkg::cmd_type              cmd,
   output kt2ca_pkg::sts_type              sts,
   input  logic signed [kt2ca_pkg::W-1:0]  meas_x,
   input  logic signed [kt2ca_pkg::W-1:0]  meas_y,
   input  logic                            csr_wr_en,
   input  logic [kt2ca_pkg::CSR_IW-1:0]    csr_index,
   input  logic [kt2ca_pkg::CFG_W-1:0]     csr_wdata,
   output logic signed [kt2ca_pkg::W-1:0]  est_out [6],
   output logic [kt2ca_pkg::VAR_W-1:0]     var_out [6]
);
   localparam int W = kt2ca_pkg::W;
   localparam int F = kt2ca_pkg::F;
   localparam int UA_W = kt2ca_pkg::UA_W;
   localparam logic [2*W-1:0] HALF = (2*W)'(1) << (F - 1);

   logic [kt2ca_pkg::CFG_W-1:0] cfg_ff [kt2ca_pkg::CFG_NUM];
   logic signed [W-1:0] mx_ff, my_ff;
   logic [W-1:0] mem [kt2ca_pkg::MEM_DEPTH];
   logic [kt2ca_pkg::MEM_DEPTH-1:0] valid_ff;
   logic signed [W-1:0] rd_a_ff, rd_b_ff, res_ff, res_in, wdata, mul_res, div_q, ld_val;
   logic [2*W-1:0] prod_ff, rnd;
   logic neg_ff;
   logic [UA_W-1:0] ra, rb, wa;
   logic [W-1:0] mag_a, mag_b, lim, mag_m;
   logic [2*W-F-1:0] rsh;
   logic signed [W-1:0] cap_est_ff [2][3];
   logic [kt2ca_pkg::VAR_W-1:0] cap_var_ff [2][3];
   logic [kt2ca_pkg::VAR_W-1:0] wvar;
   logic div_busy, div_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff[kt2ca_pkg::CSR_TIME_STEP] <= kt2ca_pkg::RST_DT;
         cfg_ff[kt2ca_pkg::CSR_PROC_NOISE_POS] <= kt2ca_pkg::RST_QPOS;
         cfg_ff[kt2ca_pkg::CSR_PROC_NOISE_VEL] <= kt2ca_pkg::RST_QVEL;
         cfg_ff[kt2ca_pkg::CSR_PROC_NOISE_ACC] <= kt2ca_pkg::RST_QACC;
         cfg_ff[kt2ca_pkg::CSR_MEAS_NOISE_X] <= kt2ca_pkg::RST_RX;
         cfg_ff[kt2ca_pkg::CSR_MEAS_NOISE_Y] <= kt2ca_pkg::RST_RY;
      end else if (csr_wr_en && (csr_index < kt2ca_pkg::CSR_IW'(kt2ca_pkg::CFG_NUM))) begin
         cfg_ff[csr_index] <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_meas) begin
         mx_ff <= meas_x;
         my_ff <= meas_y;
      end
   end

   assign ra = kt2ca_pkg::phys_addr(cmd.uop.srca, cmd.axis);
   assign rb = kt2ca_pkg::phys_addr(cmd.uop.srcb, cmd.axis);
   assign wa = kt2ca_pkg::phys_addr(cmd.uop.dst, cmd.axis);

   // Unwritten words read as their reset value until first written.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.wb) begin
         valid_ff[wa] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wb) begin
         mem[wa] <= wdata;
      end
      rd_a_ff <= valid_ff[ra] ? mem[ra] : kt2ca_pkg::reset_val(ra);
      rd_b_ff <= valid_ff[rb] ? mem[rb] : kt2ca_pkg::reset_val(rb);
   end

   always_comb begin
      mag_a = rd_a_ff[W-1] ? W'(-rd_a_ff) : W'(rd_a_ff);
      mag_b = rd_b_ff[W-1] ? W'(-rd_b_ff) : W'(rd_b_ff);
      unique case (cmd.uop.srcb)
         kt2ca_pkg::SRC_DT: ld_val = W'(cfg_ff[kt2ca_pkg::CSR_TIME_STEP]);
         kt2ca_pkg::SRC_Q0: ld_val = W'(cfg_ff[kt2ca_pkg::CSR_PROC_NOISE_POS]);
         kt2ca_pkg::SRC_Q1: ld_val = W'(cfg_ff[kt2ca_pkg::CSR_PROC_NOISE_VEL]);
         kt2ca_pkg::SRC_Q2: ld_val = W'(cfg_ff[kt2ca_pkg::CSR_PROC_NOISE_ACC]);
         kt2ca_pkg::SRC_R:  ld_val = cmd.axis ? W'(cfg_ff[kt2ca_pkg::CSR_MEAS_NOISE_Y]) :
                                                W'(cfg_ff[kt2ca_pkg::CSR_MEAS_NOISE_X]);
         kt2ca_pkg::SRC_Z:  ld_val = cmd.axis ? my_ff : mx_ff;
         default:           ld_val = '0;
      endcase
      unique case (cmd.uop.op)
         kt2ca_pkg::OP_LD:  res_in = ld_val;
         kt2ca_pkg::OP_ADD: res_in = kt2ca_pkg::sat_add(rd_a_ff, rd_b_ff, 1'b0);
         kt2ca_pkg::OP_SUB: res_in = kt2ca_pkg::sat_add(rd_a_ff, rd_b_ff, 1'b1);
         kt2ca_pkg::OP_SHR: res_in = rd_a_ff >>> 1;
         default:           res_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         prod_ff <= mag_a * mag_b;
         neg_ff <= rd_a_ff[W-1] ^ rd_b_ff[W-1];
         res_ff <= res_in;
      end
   end

   // Round to nearest with ties away from zero on the magnitude, then saturate.
   always_comb begin
      rnd = prod_ff + HALF;
      rsh = rnd[2*W-1:F];
      lim = neg_ff ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      mag_m = (rsh > (2*W-F)'(lim)) ? lim : rsh[W-1:0];
      mul_res = neg_ff ? -$signed(mag_m) : $signed(mag_m);
      unique case (cmd.uop.op)
         kt2ca_pkg::OP_MUL: wdata = mul_res;
         kt2ca_pkg::OP_DIV: wdata = div_q;
         default:           wdata = res_ff;
      endcase
      wvar = wdata[W-1] ? '0 : wdata[kt2ca_pkg::VAR_W-1:0];
   end

   kt2ca_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (rd_a_ff),
      .den   (rd_b_ff),
      .busy  (div_busy),
      .done  (div_done),
      .quo   (div_q)
   );

   assign sts.div_busy = div_busy;
   assign sts.div_done = div_done;

   // The last write of each reported word in an item is its final value.
   always_ff @(posedge clock) begin
      if (cmd.wb) begin
         if (cmd.uop.dst < kt2ca_pkg::A_C0) begin
            cap_est_ff[cmd.axis][cmd.uop.dst[1:0]] <= wdata;
         end
         if (cmd.uop.dst == kt2ca_pkg::A_C0) begin
            cap_var_ff[cmd.axis][0] <= wvar;
         end
         if (cmd.uop.dst == kt2ca_pkg::A_C3) begin
            cap_var_ff[cmd.axis][1] <= wvar;
         end
         if (cmd.uop.dst == kt2ca_pkg::A_C5) begin
            cap_var_ff[cmd.axis][2] <= wvar;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         for (int i = 0; i < 6; i++) begin
            est_out[i] <= cap_est_ff[i / 3][i % 3];
            var_out[i] <= cap_var_ff[i / 3][i % 3];
         end
      end
   end
endmodule

// File: design/kt2ca_ctrl.sv
// Sequencer: walks the microcode once per axis and runs the word handshakes.
// Depends on kt2ca_pkg.
module kt2ca_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output kt2ca_pkg::cmd_type cmd,
   input  kt2ca_pkg::sts_type sts
);
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_EXEC,
      ST_DIVW,
      ST_WRITE,
      ST_FINISH
   } state_type;

   state_type state_ff;
   logic [kt2ca_pkg::PC_W-1:0] pc_ff;
   logic axis_ff, rsp_valid_ff;
   kt2ca_pkg::uop_type uop;
   logic out_free;

   assign uop = kt2ca_pkg::uop_at(pc_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pc_ff <= '0;
         axis_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // A new result raises valid; otherwise valid holds until the word is taken.
         rsp_valid_ff <= ((state_ff == ST_FINISH) && out_free) ||
                         (rsp_valid_ff && !rsp_ready);
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  pc_ff <= '0;
                  axis_ff <= 1'b0;
                  state_ff <= ST_READ;
               end
            end
            ST_READ: state_ff <= ST_EXEC;
            ST_EXEC: state_ff <= (uop.op == kt2ca_pkg::OP_DIV) ? ST_DIVW : ST_WRITE;
            ST_DIVW: begin
               if (sts.div_done) begin
                  state_ff <= ST_WRITE;
               end
            end
            ST_WRITE: begin
               if (pc_ff == kt2ca_pkg::LAST_PC) begin
                  pc_ff <= '0;
                  if (axis_ff) begin
                     state_ff <= ST_FINISH;
                  end else begin
                     axis_ff <= 1'b1;
                     state_ff <= ST_READ;
                  end
               end else begin
                  pc_ff <= pc_ff + 1'b1;
                  state_ff <= ST_READ;
               end
            end
            ST_FINISH: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.uop = uop;
      cmd.axis = axis_ff;
      cmd.load_meas = (state_ff == ST_IDLE) && req_valid;
      cmd.exec = (state_ff == ST_EXEC);
      cmd.div_start = (state_ff == ST_EXEC) && (uop.op == kt2ca_pkg::OP_DIV);
      cmd.wb = (state_ff == ST_WRITE);
      cmd.load_out = (state_ff == ST_FINISH) && out_free;
   end
endmodule

// File: dv/kalman_track_2d_const_accel_tb.sv
// Self-checking testbench for the two-axis constant-acceleration Kalman tracker.
// Holds its own fixed-point tracker model; depends on kt2ca_pkg and the tracker RTL.
`timescale 1ns / 100ps

module kalman_track_2d_const_accel_tb;

   localparam longint SMAX = 64'sd2147483647;
   localparam longint SMIN = -64'sd2147483648;
   // A word's processing time plus a small margin for stalls on both sides.
   localparam int LATENCY = 800;
   localparam longint CYCLE_LIMIT = 64'd6000000;

   typedef struct {
      logic signed [31:0] est [6];
      logic [30:0]        vars [6];
   } track_word_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic signed [31:0] req_meas_x;
   logic signed [31:0] req_meas_y;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_est_pos_x, rsp_est_vel_x, rsp_est_acc_x;
   logic signed [31:0] rsp_est_pos_y, rsp_est_vel_y, rsp_est_acc_y;
   logic [30:0]        rsp_var_pos_x, rsp_var_vel_x, rsp_var_acc_x;
   logic [30:0]        rsp_var_pos_y, rsp_var_vel_y, rsp_var_acc_y;
   logic               csr_wr_en;
   logic [kt2ca_pkg::CSR_IW-1:0] csr_index;
   logic [30:0]        csr_wdata;

   // Model state: the six filter registers, the state vector and both covariance blocks.
   longint         trk_regs [6];
   longint         trk_state [6];
   longint         trk_cov [12];
   track_word_type expected_words [$];
   int             error_count = 0;
   longint         cycle_count = 0;
   bit             idle_on;

   kalman_track_2d_const_accel i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_meas_x(req_meas_x), .req_meas_y(req_meas_y),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_est_pos_x(rsp_est_pos_x), .rsp_est_vel_x(rsp_est_vel_x),
      .rsp_est_acc_x(rsp_est_acc_x), .rsp_est_pos_y(rsp_est_pos_y),
      .rsp_est_vel_y(rsp_est_vel_y), .rsp_est_acc_y(rsp_est_acc_y),
      .rsp_var_pos_x(rsp_var_pos_x), .rsp_var_vel_x(rsp_var_vel_x),
      .rsp_var_acc_x(rsp_var_acc_x), .rsp_var_pos_y(rsp_var_pos_y),
      .rsp_var_vel_y(rsp_var_vel_y), .rsp_var_acc_y(rsp_var_acc_y),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Fixed-point helpers. Every value fits in 32 signed bits, so products fit in
   // 64 bits and the rounding can be done directly on the magnitude.
   function automatic longint clamp32(longint v);
      if (v > SMAX) return SMAX;
      if (v < SMIN) return SMIN;
      return v;
   endfunction

   function automatic longint fx_mul(longint a, longint b);
      longint unsigned ma, mb, p;
      bit neg;
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      neg = (a < 0) != (b < 0);
      p = (ma * mb + 64'd32768) >> 16;
      if (neg) return (p > 64'd2147483648) ? SMIN : -longint'(p);
      return (p > 64'd2147483647) ? SMAX : longint'(p);
   endfunction

   // Truncating divide; a zero divisor gives zero gain.
   function automatic longint fx_div(longint a, longint b);
      longint unsigned ma, mb, q;
      bit neg;
      if (b == 0) return 0;
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      neg = (a < 0) != (b < 0);
      q = (ma << 16) / mb;
      if (neg) return (q > 64'd2147483648) ? SMIN : -longint'(q);
      return (q > 64'd2147483647) ? SMAX : longint'(q);
   endfunction

   function automatic longint fx_add(longint a, longint b);
      return clamp32(a + b);
   endfunction

   // Predict and update one axis; axis selects the x or y part of the state.
   task automatic update_axis(int axis, longint z, longint r);
      longint dt, h, s, innov, xp0, xp1, xp2;
      longint p [3][3], m [3][3], pp [3][3], k [3], q [3];
      int sb, cb;
      sb = axis * 3;
      cb = axis * 6;
      dt = trk_regs[kt2ca_pkg::CSR_TIME_STEP];
      h = fx_mul(dt, dt) >>> 1;
      q[0] = trk_regs[kt2ca_pkg::CSR_PROC_NOISE_POS];
      q[1] = trk_regs[kt2ca_pkg::CSR_PROC_NOISE_VEL];
      q[2] = trk_regs[kt2ca_pkg::CSR_PROC_NOISE_ACC];
      xp0 = fx_add(fx_add(trk_state[sb], fx_mul(dt, trk_state[sb+1])),
                   fx_mul(h, trk_state[sb+2]));
      xp1 = fx_add(trk_state[sb+1], fx_mul(dt, trk_state[sb+2]));
      xp2 = trk_state[sb+2];
      p[0][0] = trk_cov[cb];   p[0][1] = trk_cov[cb+1]; p[0][2] = trk_cov[cb+2];
      p[1][0] = trk_cov[cb+1]; p[1][1] = trk_cov[cb+3]; p[1][2] = trk_cov[cb+4];
      p[2][0] = trk_cov[cb+2]; p[2][1] = trk_cov[cb+4]; p[2][2] = trk_cov[cb+5];
      for (int j = 0; j < 3; j++) begin
         m[0][j] = fx_add(fx_add(p[0][j], fx_mul(dt, p[1][j])), fx_mul(h, p[2][j]));
         m[1][j] = fx_add(p[1][j], fx_mul(dt, p[2][j]));
         m[2][j] = p[2][j];
      end
      for (int i = 0; i < 3; i++) begin
         pp[i][0] = fx_add(fx_add(m[i][0], fx_mul(m[i][1], dt)), fx_mul(m[i][2], h));
         pp[i][1] = fx_add(m[i][1], fx_mul(m[i][2], dt));
         pp[i][2] = m[i][2];
      end
      for (int i = 0; i < 3; i++) pp[i][i] = fx_add(pp[i][i], q[i]);
      s = fx_add(pp[0][0], r);
      for (int i = 0; i < 3; i++) k[i] = fx_div(pp[i][0], s);
      innov = clamp32(z - xp0);
      trk_state[sb]   = fx_add(xp0, fx_mul(k[0], innov));
      trk_state[sb+1] = fx_add(xp1, fx_mul(k[1], innov));
      trk_state[sb+2] = fx_add(xp2, fx_mul(k[2], innov));
      trk_cov[cb]   = clamp32(pp[0][0] - fx_mul(k[0], pp[0][0]));
      trk_cov[cb+1] = clamp32(pp[0][1] - fx_mul(k[0], pp[0][1]));
      trk_cov[cb+2] = clamp32(pp[0][2] - fx_mul(k[0], pp[0][2]));
      trk_cov[cb+3] = clamp32(pp[1][1] - fx_mul(k[1], pp[0][1]));
      trk_cov[cb+4] = clamp32(pp[1][2] - fx_mul(k[1], pp[0][2]));
      trk_cov[cb+5] = clamp32(pp[2][2] - fx_mul(k[2], pp[0][2]));
   endtask

   task automatic predict_track(logic signed [31:0] zx, logic signed [31:0] zy);
      track_word_type w;
      longint v;
      update_axis(0, longint'(zx), trk_regs[kt2ca_pkg::CSR_MEAS_NOISE_X]);
      update_axis(1, longint'(zy), trk_regs[kt2ca_pkg::CSR_MEAS_NOISE_Y]);
      for (int i = 0; i < 6; i++) begin
         w.est[i] = trk_state[i][31:0];
         // Variances read as zero when negative.
         v = trk_cov[(i / 3) * 6 + ((i % 3) == 0 ? 0 : (i % 3) == 1 ? 3 : 5)];
         w.vars[i] = (v < 0) ? 31'd0 : v[30:0];
      end
      expected_words.push_back(w);
   endtask

   task automatic reset_track_model();
      trk_regs[kt2ca_pkg::CSR_TIME_STEP] = kt2ca_pkg::RST_DT;
      trk_regs[kt2ca_pkg::CSR_PROC_NOISE_POS] = kt2ca_pkg::RST_QPOS;
      trk_regs[kt2ca_pkg::CSR_PROC_NOISE_VEL] = kt2ca_pkg::RST_QVEL;
      trk_regs[kt2ca_pkg::CSR_PROC_NOISE_ACC] = kt2ca_pkg::RST_QACC;
      trk_regs[kt2ca_pkg::CSR_MEAS_NOISE_X] = kt2ca_pkg::RST_RX;
      trk_regs[kt2ca_pkg::CSR_MEAS_NOISE_Y] = kt2ca_pkg::RST_RY;
      for (int i = 0; i < 6; i++) trk_state[i] = 0;
      for (int a = 0; a < 2; a++) begin
         trk_cov[a*6] = 100 * kt2ca_pkg::ONE_Q;
         trk_cov[a*6+1] = 0;
         trk_cov[a*6+2] = 0;
         trk_cov[a*6+3] = kt2ca_pkg::TENTH_Q;
         trk_cov[a*6+4] = 0;
         trk_cov[a*6+5] = kt2ca_pkg::TENTH_Q;
      end
   endtask

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d, expected %0d at cycle %0d", what, got, want,
               cycle_count);
      error_count++;
   endtask

   // Sends one measurement word and holds it until it is taken.
   task automatic send_fix(logic signed [31:0] zx, logic signed [31:0] zy);
      while (idle_on && ($urandom_range(99) < 35)) @(posedge clock);
      req_valid <= 1'b1;
      req_meas_x <= zx;
      req_meas_y <= zy;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_track(zx, zy);
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Waits until every predicted word has come back, then lets the engine settle.
   task automatic drain_results();
      while (expected_words.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   task automatic write_reg(logic [kt2ca_pkg::CSR_IW-1:0] idx, logic [30:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx < kt2ca_pkg::CFG_NUM) trk_regs[idx] = val;
      @(posedge clock);
   endtask

   task automatic write_all_regs(logic [30:0] dt, logic [30:0] qp, logic [30:0] qv,
                                 logic [30:0] qa, logic [30:0] rx, logic [30:0] ry);
      drain_results();
      write_reg(kt2ca_pkg::CSR_TIME_STEP, dt);
      write_reg(kt2ca_pkg::CSR_PROC_NOISE_POS, qp);
      write_reg(kt2ca_pkg::CSR_PROC_NOISE_VEL, qv);
      write_reg(kt2ca_pkg::CSR_PROC_NOISE_ACC, qa);
      write_reg(kt2ca_pkg::CSR_MEAS_NOISE_X, rx);
      write_reg(kt2ca_pkg::CSR_MEAS_NOISE_Y, ry);
   endtask

   // Field extremes of the measurement word under reset settings.
   task automatic test_field_extremes();
      send_fix(32'sd0, 32'sd0);
      send_fix(32'sh7fffffff, 32'sh80000000);
      send_fix(32'sh80000000, 32'sh7fffffff);
      send_fix(32'sd65536, -32'sd65536);
      send_fix(-32'sd1, 32'sd1);
      send_fix(32'sh55555555, 32'shaaaaaaaa);
      send_fix(32'shaaaaaaaa, 32'sh55555555);
      send_fix(32'sd0, 32'sd0);
   endtask

   // Zero time step with zero noise collapses the position variance after the
   // first fix, so later fixes see a zero innovation variance and zero gain.
   task automatic test_zero_gain();
      write_all_regs(31'd0, 31'd0, 31'd0, 31'd0, 31'd0, 31'd0);
      send_fix(32'sd12345, -32'sd777);
      send_fix(32'sh7fffffff, 32'sh80000000);
      send_fix(32'sd1, 32'sd1);
   endtask

   // Largest register values saturate many sums and products; then a tiny time step.
   task automatic test_saturation();
      write_all_regs(31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff,
                     31'h7fffffff, 31'h7fffffff);
      send_fix(32'sh7fffffff, 32'sh80000000);
      send_fix(32'sh80000000, 32'sh7fffffff);
      send_fix(32'sd0, -32'sd1);
      write_all_regs(31'd1, 31'd0, 31'd1, 31'd0, 31'h7fffffff, 31'd0);
      send_fix(32'sd100, -32'sd100);
      send_fix(32'sh40000000, 32'shc0000000);
   endtask

   // A write to an index past the last register must be ignored.
   task automatic test_unknown_index();
      drain_results();
      write_reg(kt2ca_pkg::CSR_IW'(kt2ca_pkg::CFG_NUM), 31'h12345);
      write_reg(kt2ca_pkg::CSR_IW'(kt2ca_pkg::CFG_NUM + 1), 31'h7fffffff);
      send_fix(32'sd4096, 32'sd8192);
   endtask

   function automatic logic signed [31:0] rand_fix(int mode);
      case (mode)
         0: return $urandom;
         1: return $signed(32'($urandom_range(1 << 22))) - (1 << 21);
         default: return $signed(32'($urandom_range(1 << 26))) - (1 << 25);
      endcase
   endfunction

   // Random phases: a realistic track with moderate settings, then wild values.
   task automatic test_random_tracks(int words, int phase);
      int mode;
      logic signed [31:0] px, py;
      px = rand_fix(2);
      py = rand_fix(2);
      case (phase)
         0: write_all_regs(31'd65536, 31'd6554, 31'd6554, 31'd6553600, 31'd1638400,
                           31'd1638400);
         1: write_all_regs(31'($urandom_range(1 << 17)), 31'($urandom_range(1 << 18)),
                           31'($urandom_range(1 << 18)), 31'($urandom_range(1 << 24)),
                           31'($urandom_range(1 << 22)), 31'($urandom_range(1 << 22)));
         default: write_all_regs(31'($urandom), 31'($urandom), 31'($urandom),
                                 31'($urandom), 31'($urandom), 31'($urandom));
      endcase
      for (int n = 0; n < words; n++) begin
         mode = $urandom_range(9);
         if (mode < 7) begin
            // Smooth path with small noise on each fix.
            px = px + rand_fix(1) / 16;
            py = py + rand_fix(1) / 16;
            send_fix(px, py);
         end else begin
            send_fix(rand_fix(mode == 9 ? 0 : 2), rand_fix(mode == 9 ? 0 : 2));
         end
      end
   endtask

   // Result checker: compares each accepted word with the oldest prediction.
   always @(posedge clock) begin
      track_word_type w;
      logic signed [31:0] got_est [6];
      logic [30:0]        got_var [6];
      if (!reset && rsp_valid && rsp_ready) begin
         got_est = '{rsp_est_pos_x, rsp_est_vel_x, rsp_est_acc_x,
                     rsp_est_pos_y, rsp_est_vel_y, rsp_est_acc_y};
         got_var = '{rsp_var_pos_x, rsp_var_vel_x, rsp_var_acc_x,
                     rsp_var_pos_y, rsp_var_vel_y, rsp_var_acc_y};
         if (expected_words.size() == 0) begin
            report_mismatch("unexpected word", 1, 0);
         end else begin
            w = expected_words.pop_front();
            for (int i = 0; i < 6; i++) begin
               if (got_est[i] !== w.est[i]) begin
                  report_mismatch($sformatf("estimate %0d", i), got_est[i], w.est[i]);
               end
               if (got_var[i] !== w.vars[i]) begin
                  report_mismatch($sformatf("variance %0d", i), got_var[i], w.vars[i]);
               end
            end
         end
      end
   end

   // Receiver stalls at random while idling is on.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !idle_on || ($urandom_range(99) >= 35);
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("kalman_track_2d_const_accel regression: fail");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_meas_x = '0;
      req_meas_y = '0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      idle_on = 1'b1;
      reset_track_model();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_field_extremes();
      test_zero_gain();
      test_saturation();
      test_unknown_index();
      test_random_tracks(350, 0);
      // A stretch with no idling on either side.
      idle_on = 1'b0;
      test_random_tracks(300, 1);
      idle_on = 1'b1;
      test_random_tracks(300, 2);
      // Hold the sender until all outstanding words are back.
      drain_results();
      test_random_tracks(420, 1);

      drain_results();
      if (error_count == 0) begin
         $display("kalman_track_2d_const_accel regression: pass");
      end else begin
         $display("kalman_track_2d_const_accel regression: fail");
      end
      $finish;
   end

endmodule
